FILE: rtl/core/sha1md_pkg.sv
// shared constants, types and command/status structs for the sha-1 digest engine
package sha1md_pkg;

  localparam int WordW     = 32;
  localparam int NumWords  = 5;
  localparam int BlockBits = 512;
  localparam int CountW    = 61;
  localparam int FillW     = 6;
  localparam int RoundW    = 7;

  localparam logic [RoundW-1:0] LastRound = 7'd79;
  localparam logic [RoundW-1:0] Round20   = 7'd20;
  localparam logic [RoundW-1:0] Round40   = 7'd40;
  localparam logic [RoundW-1:0] Round60   = 7'd60;
  localparam logic [FillW-1:0]  LenStart  = 6'd56;
  localparam logic [FillW-1:0]  LastByte  = 6'h3F;
  localparam logic [7:0]        PadMark   = 8'h80;

  typedef logic [NumWords-1:0][WordW-1:0] words_t;

  // word 0 sits in the low bits
  localparam words_t HInit = {32'hC3D2E1F0, 32'h10325476, 32'h98BADCFE,
                              32'hEFCDAB89, 32'h67452301};

  localparam logic [WordW-1:0] K0 = 32'h5A827999;
  localparam logic [WordW-1:0] K1 = 32'h6ED9EBA1;
  localparam logic [WordW-1:0] K2 = 32'h8F1BBCDC;
  localparam logic [WordW-1:0] K3 = 32'hCA62C1D6;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PAD,
    ST_ROUND,
    ST_ADD,
    ST_DONE
  } state_t;

  typedef enum logic [1:0] {
    BS_MSG,
    BS_MARK,
    BS_ZERO,
    BS_LEN
  } byte_sel_t;

  typedef struct packed {
    logic      shift;
    byte_sel_t sel;
    logic      count_inc;
    logic      init_work;
    logic      round;
    logic      add;
    logic      finish;
  } cmd_t;

  typedef struct packed {
    logic [FillW-1:0] fill;
    logic             round_last;
    logic             out_busy;
  } status_t;

endpackage

FILE: rtl/core/sha1md_datapath.sv
// sha-1 datapath: block shift register, schedule, round logic, chaining words, digest register
module sha1md_datapath import sha1md_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  cmd_t                   cmd,
  input  logic [7:0]             msg_byte,
  output status_t                status,
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  output logic [NumWords*WordW-1:0] m_axis_tdata  // digest_word_0 .. digest_word_4
);

  logic [BlockBits-1:0] blk;
  logic [FillW-1:0]     fill;
  logic [CountW-1:0]    count;
  logic [RoundW-1:0]    rnd;
  logic [WordW-1:0]     a, b, c, d, e;
  words_t               h;
  words_t               dig;
  logic                 out_valid;

  logic [7:0]       byte_in;
  logic [63:0]      bit_len;
  logic [2:0]       lidx;
  logic [7:0]       len_byte;
  logic [WordW-1:0] w0, w2, w8, w13, wx, wnew;
  logic [WordW-1:0] f, k, temp;
  words_t           work;

  assign bit_len  = {count, 3'b000};
  assign lidx     = 3'd7 - fill[2:0];
  assign len_byte = bit_len[{lidx, 3'b000} +: 8];

  always_comb begin
    case (cmd.sel)
      BS_MSG:  byte_in = msg_byte;
      BS_MARK: byte_in = PadMark;
      BS_ZERO: byte_in = 8'h00;
      BS_LEN:  byte_in = len_byte;
      default: byte_in = 8'h00;
    endcase
  end

  // the block register doubles as the 16-word schedule window, oldest word on top
  assign w0   = blk[511:480];
  assign w2   = blk[447:416];
  assign w8   = blk[255:224];
  assign w13  = blk[95:64];
  assign wx   = w13 ^ w8 ^ w2 ^ w0;
  assign wnew = {wx[30:0], wx[31]};

  always_comb begin
    if (rnd < Round20) begin
      f = d ^ (b & (c ^ d));
      k = K0;
    end else if (rnd < Round40) begin
      f = b ^ c ^ d;
      k = K1;
    end else if (rnd < Round60) begin
      f = (b & c) | (d & (b | c));
      k = K2;
    end else begin
      f = b ^ c ^ d;
      k = K3;
    end
  end

  assign temp = {a[26:0], a[31:27]} + f + e + k + w0;
  assign work = {e, d, c, b, a};

  always_ff @(posedge clk) begin
    if (cmd.shift) begin
      blk <= {blk[BlockBits-9:0], byte_in};
    end else if (cmd.round) begin
      blk <= {blk[BlockBits-WordW-1:0], wnew};
    end
    if (cmd.init_work) begin
      a <= h[0];
      b <= h[1];
      c <= h[2];
      d <= h[3];
      e <= h[4];
    end else if (cmd.round) begin
      e <= d;
      d <= c;
      c <= {b[1:0], b[31:2]};
      b <= a;
      a <= temp;
    end
    if (cmd.finish) begin
      dig <= h;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill      <= '0;
      count     <= '0;
      rnd       <= '0;
      h         <= HInit;
      out_valid <= 1'b0;
    end else begin
      if (cmd.shift) begin
        fill <= fill + 1'b1;
      end
      if (cmd.init_work) begin
        rnd <= '0;
      end else if (cmd.round) begin
        rnd <= rnd + 1'b1;
      end
      if (cmd.finish) begin
        count <= '0;
      end else if (cmd.count_inc) begin
        count <= count + 1'b1;
      end
      if (cmd.finish) begin
        h <= HInit;
      end else if (cmd.add) begin
        for (int i = 0; i < NumWords; i++) begin
          h[i] <= h[i] + work[i];
        end
      end
      if (cmd.finish) begin
        out_valid <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign status.fill       = fill;
  assign status.round_last = (rnd == LastRound);
  assign status.out_busy   = out_valid && !m_axis_tready;

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = dig;

endmodule

FILE: rtl/core/sha1md_ctrl.sv
// sha-1 controller: byte intake, padding sequence, round and finish sequencing
module sha1md_ctrl import sha1md_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    s_axis_tvalid,
  input  logic    s_axis_tlast,
  input  logic    s_axis_tuser,
  output logic    s_axis_tready,
  input  status_t status,
  output cmd_t    cmd
);

  state_t state, state_next;
  logic   marked, marked_next;    // 0x80 already placed
  logic   len_ok, len_ok_next;    // length goes into the current block
  logic   eom_pend, eom_pend_next;
  logic   accept;
  logic   block_full;

  assign accept     = s_axis_tvalid && (state == ST_IDLE);
  assign block_full = (status.fill == LastByte);

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      marked   <= 1'b0;
      len_ok   <= 1'b0;
      eom_pend <= 1'b0;
    end else begin
      state    <= state_next;
      marked   <= marked_next;
      len_ok   <= len_ok_next;
      eom_pend <= eom_pend_next;
    end
  end

  always_comb begin
    state_next    = state;
    marked_next   = marked;
    len_ok_next   = len_ok;
    eom_pend_next = eom_pend;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          if (s_axis_tuser && block_full) begin
            state_next    = ST_ROUND;
            eom_pend_next = s_axis_tlast;
          end else if (s_axis_tlast) begin
            state_next = ST_PAD;
          end
        end
      end
      ST_PAD: begin
        if (!marked) begin
          marked_next = 1'b1;
          if (status.fill < LenStart) begin
            len_ok_next = 1'b1;
          end
        end
        if (block_full) begin
          state_next = ST_ROUND;
        end
      end
      ST_ROUND: begin
        if (status.round_last) begin
          state_next = ST_ADD;
        end
      end
      ST_ADD: begin
        if (!marked) begin
          state_next = eom_pend ? ST_PAD : ST_IDLE;
        end else if (len_ok) begin
          state_next = ST_DONE;
        end else begin
          // marker landed past the length slot: one more block
          len_ok_next = 1'b1;
          state_next  = ST_PAD;
        end
      end
      ST_DONE: begin
        if (!status.out_busy) begin
          state_next    = ST_IDLE;
          marked_next   = 1'b0;
          len_ok_next   = 1'b0;
          eom_pend_next = 1'b0;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd           = '0;
    cmd.sel       = BS_MSG;
    s_axis_tready = 1'b0;
    case (state)
      ST_IDLE: begin
        s_axis_tready = 1'b1;
        if (accept && s_axis_tuser) begin
          cmd.shift     = 1'b1;
          cmd.count_inc = 1'b1;
          cmd.init_work = block_full;
        end
      end
      ST_PAD: begin
        cmd.shift     = 1'b1;
        cmd.init_work = block_full;
        if (!marked) begin
          cmd.sel = BS_MARK;
        end else if (len_ok && (status.fill >= LenStart)) begin
          cmd.sel = BS_LEN;
        end else begin
          cmd.sel = BS_ZERO;
        end
      end
      ST_ROUND: cmd.round  = 1'b1;
      ST_ADD:   cmd.add    = 1'b1;
      ST_DONE:  cmd.finish = !status.out_busy;
      default: ;
    endcase
  end

endmodule

FILE: rtl/core/sha1_message_digest_top.sv
// sha-1 digest engine top level: controller plus datapath
// bytes are taken one per cycle while idle; the 64th byte of a block stalls input while
// the block runs 80 rounds on one shared round unit and then the chaining add
// end of message: pad bytes fill out the pad block, then its rounds and add; one or two
// pad blocks, then the digest register loads once any earlier digest has been taken
// the digest register lets the next message start while a digest waits to be taken
// reset (rst, synchronous): initial chaining words, byte count zero, no digest pending
module sha1_message_digest_top import sha1md_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [7:0]   s_axis_tdata,   // msg_byte
  input  logic         s_axis_tuser,   // byte_present
  input  logic         s_axis_tlast,   // end_of_message
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [159:0] m_axis_tdata    // digest_word_0 .. digest_word_4, 32 bits each
);

  cmd_t    cmd;
  status_t status;

  sha1md_ctrl u_ctrl (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tlast  (s_axis_tlast),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tready (s_axis_tready),
    .status        (status),
    .cmd           (cmd)
  );

  sha1md_datapath u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .msg_byte      (s_axis_tdata),
    .status        (status),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

endmodule

FILE: tb/tb_sha1_message_digest_top.sv
`timescale 1ns / 100ps
// self-checking testbench for the sha-1 digest engine, with its own byte-level sha-1 predictor
module tb_sha1_message_digest_top import sha1md_pkg::*;;

  localparam int NumItems   = 1800;
  localparam int HoldCycles = 800;
  localparam int DrainWait  = 400;
  localparam int CycleLimit = 400000;
  localparam int NumDir     = 12;

  localparam words_t EmptyDigest = {32'hafd80709, 32'h95601890, 32'h3255bfef,
                                    32'h5e6b4b0d, 32'hda39a3ee};
  localparam words_t AbcDigest   = {32'h9cd0d89d, 32'h7850c26c, 32'hba3e2571,
                                    32'h4706816a, 32'ha9993e36};

  typedef struct packed {
    logic [7:0] mbyte;
    logic       present;
    logic       eom;
  } msg_item_t;

  typedef struct packed {
    msg_item_t item;
    logic      known;
    words_t    digest;
  } dir_row_t;

  logic         clk;
  logic         rst;
  logic         s_axis_tvalid;
  logic         s_axis_tready;
  logic [7:0]   s_axis_tdata;
  logic         s_axis_tuser;
  logic         s_axis_tlast;
  logic         m_axis_tvalid;
  logic         m_axis_tready;
  logic [159:0] m_axis_tdata;

  // predictor state
  words_t      hash_state = HInit;
  logic [7:0]  blk_bytes [64];
  logic [60:0] msg_len = '0;

  words_t   pending_digests [$];
  dir_row_t dir_rows [NumDir];
  int       errors = 0;
  int       reported = 0;
  int       cycle_count = 0;
  int       stall_left = 0;
  bit       calm = 1'b0;
  bit       rand_phase = 1'b0;
  logic     hold_off;
  words_t   rx_want;
  words_t   rx_got;

  sha1_message_digest_top i_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  function automatic void sha1_compress();
    logic [31:0] w [16];
    logic [31:0] a, b, c, d, e, f, k, t, wi;
    for (int i = 0; i < 16; i++) begin
      w[i] = {blk_bytes[4*i], blk_bytes[4*i+1], blk_bytes[4*i+2], blk_bytes[4*i+3]};
    end
    a = hash_state[0];
    b = hash_state[1];
    c = hash_state[2];
    d = hash_state[3];
    e = hash_state[4];
    for (int i = 0; i < 80; i++) begin
      if (i < 16) begin
        wi = w[i];
      end else begin
        t = w[(i-3) & 15] ^ w[(i-8) & 15] ^ w[(i-14) & 15] ^ w[i & 15];
        wi = {t[30:0], t[31]};
        w[i & 15] = wi;
      end
      if (i < 20) begin
        f = d ^ (b & (c ^ d));
        k = K0;
      end else if (i < 40) begin
        f = b ^ c ^ d;
        k = K1;
      end else if (i < 60) begin
        f = (b & c) | (d & (b | c));
        k = K2;
      end else begin
        f = b ^ c ^ d;
        k = K3;
      end
      t = {a[26:0], a[31:27]} + f + e + k + wi;
      e = d;
      d = c;
      c = {b[1:0], b[31:2]};
      b = a;
      a = t;
    end
    hash_state[0] = hash_state[0] + a;
    hash_state[1] = hash_state[1] + b;
    hash_state[2] = hash_state[2] + c;
    hash_state[3] = hash_state[3] + d;
    hash_state[4] = hash_state[4] + e;
  endfunction

  // takes one item; returns 1 with the digest when the item closes the message
  function automatic bit sha1_absorb(input msg_item_t it, output words_t dg);
    int pos;
    logic [63:0] bitlen;
    dg = '0;
    if (it.present) begin
      pos = int'(msg_len[5:0]);
      blk_bytes[pos] = it.mbyte;
      msg_len = msg_len + 1'b1;
      if (pos == 63) sha1_compress();
    end
    if (!it.eom) return 1'b0;
    bitlen = {msg_len, 3'b000};
    pos = int'(msg_len[5:0]);
    blk_bytes[pos] = PadMark;
    pos++;
    // no room for the length: pad out this block and start another
    if (pos > 56) begin
      while (pos < 64) begin
        blk_bytes[pos] = 8'h00;
        pos++;
      end
      sha1_compress();
      pos = 0;
    end
    while (pos < 56) begin
      blk_bytes[pos] = 8'h00;
      pos++;
    end
    for (int i = 0; i < 8; i++) begin
      blk_bytes[56+i] = bitlen[63-8*i -: 8];
    end
    sha1_compress();
    dg = hash_state;
    hash_state = HInit;
    msg_len = '0;
    return 1'b1;
  endfunction

  task automatic send_msg_item(input msg_item_t it, input bit known, input words_t want);
    words_t dg;
    if (!calm && $urandom_range(0, 5) == 0) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= 8'($urandom_range(0, 255));
      s_axis_tuser  <= 1'($urandom_range(0, 1));
      s_axis_tlast  <= 1'($urandom_range(0, 1));
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= it.mbyte;
    s_axis_tuser  <= it.present;
    s_axis_tlast  <= it.eom;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    if (sha1_absorb(it, dg)) pending_digests.push_back(known ? want : dg);
  endtask

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    while (cycle_count < CycleLimit) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Verification failed");
    $finish;
  end

  // output side: random stalls, one long hold-off, digest checks
  initial begin
    m_axis_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (m_axis_tvalid && m_axis_tready) begin
        rx_got = m_axis_tdata;
        if (pending_digests.size() == 0) begin
          errors++;
          if (reported < 10) $display("unexpected digest %h", rx_got);
          reported++;
        end else begin
          rx_want = pending_digests.pop_front();
          for (int w = 0; w < NumWords; w++) begin
            if (rx_got[w] !== rx_want[w]) begin
              errors++;
              if (reported < 10)
                $display("digest word %0d mismatch: expected %h, got %h",
                         w, rx_want[w], rx_got[w]);
              reported++;
            end
          end
        end
      end
      if (stall_left > 0) begin
        stall_left--;
      end else if (!calm && $urandom_range(0, 7) == 0) begin
        stall_left = $urandom_range(1, 9);
      end
      m_axis_tready <= !hold_off && stall_left == 0;
    end
  end

  // hold the output off long enough for the engine to back up into its input
  initial begin
    hold_off <= 1'b0;
    wait (rand_phase);
    repeat ($urandom_range(100, 1500)) @(posedge clk);
    hold_off <= 1'b1;
    repeat (HoldCycles) @(posedge clk);
    hold_off <= 1'b0;
  end

  initial begin
    msg_item_t it;
    int        len;
    int        pick;
    int        rand_items;
    bit        close_on_byte;
    rand_items = 0;
    for (int i = 0; i < 64; i++) blk_bytes[i] = 8'h00;
    rst           <= 1'b1;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= 8'h00;
    s_axis_tuser  <= 1'b0;
    s_axis_tlast  <= 1'b0;
    // mbyte, present, eom, known, digest
    dir_rows = '{
      '{'{8'h00, 1'b0, 1'b1}, 1'b1, EmptyDigest},  // empty message
      '{'{8'h5A, 1'b0, 1'b0}, 1'b0, words_t'(0)},  // empty item
      '{'{8'h61, 1'b1, 1'b0}, 1'b0, words_t'(0)},
      '{'{8'hA5, 1'b0, 1'b0}, 1'b0, words_t'(0)},
      '{'{8'h62, 1'b1, 1'b0}, 1'b0, words_t'(0)},
      '{'{8'h63, 1'b1, 1'b1}, 1'b1, AbcDigest},    // "abc", closed on its last byte
      '{'{8'hFF, 1'b0, 1'b1}, 1'b1, EmptyDigest},  // byte ignored when not present
      '{'{8'h00, 1'b1, 1'b1}, 1'b0, words_t'(0)},
      '{'{8'hFF, 1'b1, 1'b1}, 1'b0, words_t'(0)},
      '{'{8'hFF, 1'b1, 1'b0}, 1'b0, words_t'(0)},
      '{'{8'h00, 1'b0, 1'b0}, 1'b0, words_t'(0)},
      '{'{8'h00, 1'b0, 1'b1}, 1'b0, words_t'(0)}   // closing item without a byte
    };
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    for (int r = 0; r < NumDir; r++) begin
      send_msg_item(dir_rows[r].item, dir_rows[r].known, dir_rows[r].digest);
    end

    rand_phase = 1'b1;
    while (rand_items < NumItems) begin
      pick = $urandom_range(0, 19);
      if (pick < 5) begin
        // lengths around the padding boundaries of one and two blocks
        len = 64 * $urandom_range(0, 1) + $urandom_range(55, 65);
      end else if (pick == 5) begin
        len = $urandom_range(100, 200);
      end else begin
        len = $urandom_range(0, 40);
      end
      close_on_byte = 1'($urandom_range(0, 1));
      if ($urandom_range(0, 19) == 0) begin
        repeat ($urandom_range(1, 5)) begin
          it = '{8'($urandom_range(0, 255)), 1'b0, 1'b0};
          send_msg_item(it, 1'b0, '0);
        end
      end
      for (int n = 0; n < len; n++) begin
        if ($urandom_range(0, 15) == 0) begin
          it = '{8'($urandom_range(0, 255)), 1'b0, 1'b0};
          send_msg_item(it, 1'b0, '0);
        end
        it = '{8'($urandom_range(0, 255)), 1'b1, close_on_byte && n == len - 1};
        send_msg_item(it, 1'b0, '0);
        rand_items++;
      end
      if (len == 0 || !close_on_byte) begin
        it = '{8'($urandom_range(0, 255)), 1'b0, 1'b1};
        send_msg_item(it, 1'b0, '0);
        rand_items++;
      end
      if (rand_items > NumItems * 85 / 100) calm = 1'b1;
    end
    s_axis_tvalid <= 1'b0;

    while (pending_digests.size() != 0) @(posedge clk);
    repeat (DrainWait) @(posedge clk);
    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

FILE: sim.f
rtl/core/sha1md_pkg.sv
rtl/core/sha1md_datapath.sv
rtl/core/sha1md_ctrl.sv
rtl/core/sha1_message_digest_top.sv
tb/tb_sha1_message_digest_top.sv
